// ===== src/sth_pkg.sv =====
// Shared constants, types and command/status codes for the hash table engine.
// Depends on nothing; used by the controller, datapath and top level.
package sth_pkg;

  localparam int Capacity   = 1024;
  localparam int SlotW      = 10;
  localparam int Group      = 8;
  localparam int NumGroups  = Capacity / Group;
  localparam int CountW     = 11;

  localparam logic [63:0] FnvOffset = 64'd14695981039346656037;
  localparam logic [63:0] FnvPrime  = 64'd1099511628211;
  localparam logic [63:0] FibMult   = 64'd11400714819323198485;

  // FnvPrime = 2^40 + 0x1B3: one shift plus a small constant product.
  localparam int          FnvPrimeShift = 40;
  localparam logic [63:0] FnvPrimeLo    = 64'h1B3;

  localparam logic [7:0] CtrlEmpty   = 8'h80;
  localparam logic [7:0] CtrlDeleted = 8'hFE;

  // Insert refused once (live + 1) * 5 >= Capacity * 4.
  localparam logic [CountW+2:0] LoadLimit = (CountW + 3)'(Capacity * 4);

  localparam logic [1:0] CmdGetIns = 2'd0;
  localparam logic [1:0] CmdDelete = 2'd1;
  localparam logic [1:0] CmdWrite  = 2'd2;

  localparam logic [2:0] StFound    = 3'd0;
  localparam logic [2:0] StInserted = 3'd1;
  localparam logic [2:0] StDeleted  = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;
  localparam logic [2:0] StWritten  = 3'd5;

  // Controller to datapath.
  typedef struct packed {
    logic clear_step; // mark one control byte empty after reset
    logic load;      // capture request, start hashing
    logic hash_step; // one FNV byte round
    logic mul_step;  // one 32x32 partial product of the slot multiply
    logic set_base;  // derive start slot and tag
    logic rd_issue;  // issue a control/key read at probe position
    logic rd_eval;   // evaluate the returned entry
    logic do_insert;
    logic do_delete;
    logic do_write;
    logic rd_value;  // read value store at hit slot
  } sth_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_last; // clearing pass at its last slot
    logic hit;
    logic group_end;  // last slot of the current group evaluated
    logic saw_empty;  // group being evaluated held an empty slot
    logic all_seen;   // every slot visited
    logic have_free;
    logic load_full;
  } sth_stat_t;

endpackage

// ===== src/sth_datapath.sv =====
// Datapath: hash, slot multiply, probe registers and the three slot stores.
// Depends on sth_pkg; driven by sth_ctrl through sth_cmd_t.
module sth_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sth_pkg::sth_cmd_t       cmd_i,
  input  logic [63:0]             key_i,
  input  logic [sth_pkg::SlotW-1:0] slot_sel_i,
  input  logic [63:0]             value_in_i,
  input  logic [2:0]              mul_idx_i,
  output sth_pkg::sth_stat_t      stat_o,
  output logic [sth_pkg::SlotW-1:0] hit_slot_o,
  output logic [sth_pkg::SlotW-1:0] free_slot_o,
  output logic [63:0]             value_o
);

  logic [7:0]  ctrl_mem  [sth_pkg::Capacity];
  logic [63:0] key_mem   [sth_pkg::Capacity];
  logic [63:0] value_mem [sth_pkg::Capacity];

  logic [63:0] key_q, val_q, h_q, prod_q;
  logic [sth_pkg::SlotW-1:0] sel_q, pos_q, rd_pos_q, hit_q, free_q, clr_q;
  logic [2:0]  byte_q;
  logic [6:0]  tag_q;
  logic [7:0]  ctrl_rd_q;
  logic [63:0] key_rd_q, val_rd_q;
  logic [$clog2(sth_pkg::Group)-1:0] j_q;
  logic [sth_pkg::SlotW:0] visited_q;
  logic hit_q_v, free_v_q, saw_empty_q, grp_end_q;
  logic [sth_pkg::CountW-1:0] live_q;

  logic [63:0] fnv_x;
  logic        is_empty;
  logic [31:0] ma, mb;
  logic [63:0] pp;
  logic [sth_pkg::CountW+2:0] load_calc;

  always_comb begin
    ma = mul_idx_i[0] ? h_q[63:32] : h_q[31:0];
    mb = mul_idx_i[1] ? sth_pkg::FibMult[63:32] : sth_pkg::FibMult[31:0];
  end
  assign pp = 64'(ma) * 64'(mb);
  assign fnv_x = h_q ^ {56'd0, key_q[{byte_q, 3'b000} +: 8]};
  assign is_empty = (ctrl_rd_q == sth_pkg::CtrlEmpty);
  assign load_calc = (sth_pkg::CountW + 3)'((live_q + 1'b1) * 5);

  // Stores; clearing, control byte writes and value writes never collide.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      ctrl_rd_q <= ctrl_mem[pos_q];
      key_rd_q  <= key_mem[pos_q];
    end
    if (cmd_i.clear_step) ctrl_mem[clr_q] <= sth_pkg::CtrlEmpty;
    if (cmd_i.do_insert) begin
      ctrl_mem[free_q] <= {1'b0, tag_q};
      key_mem[free_q]  <= key_q;
    end
    if (cmd_i.do_delete) ctrl_mem[hit_q] <= sth_pkg::CtrlDeleted;
    if (cmd_i.do_write)  value_mem[sel_q] <= val_q;
    if (cmd_i.rd_value)  val_rd_q <= value_mem[hit_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
      clr_q  <= '0;
    end else begin
      if (cmd_i.clear_step) clr_q <= clr_q + 1'b1;
      if (cmd_i.do_insert) live_q <= live_q + 1'b1;
      if (cmd_i.do_delete) live_q <= live_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q  <= key_i;
      val_q  <= value_in_i;
      sel_q  <= slot_sel_i;
      h_q    <= sth_pkg::FnvOffset;
      byte_q <= '0;
      prod_q <= '0;
    end
    if (cmd_i.hash_step) begin
      h_q    <= (fnv_x << sth_pkg::FnvPrimeShift) + fnv_x * sth_pkg::FnvPrimeLo;
      byte_q <= byte_q + 1'b1;
    end
    // Only the top SlotW bits of the 64-bit product matter; accumulate
    // the three partial products that reach the upper word.
    if (cmd_i.mul_step) begin
      case (mul_idx_i)
        3'd0: prod_q <= pp;
        3'd1, 3'd2: prod_q <= prod_q + {pp[31:0], 32'd0};
        default: prod_q <= prod_q;
      endcase
    end
    if (cmd_i.set_base) begin
      pos_q       <= prod_q[63 -: sth_pkg::SlotW];
      tag_q       <= h_q[62:56];
      j_q         <= '0;
      visited_q   <= '0;
      hit_q_v     <= 1'b0;
      free_v_q    <= 1'b0;
      saw_empty_q <= 1'b0;
      grp_end_q   <= 1'b0;
    end
    if (cmd_i.rd_issue) begin
      rd_pos_q <= pos_q;
      pos_q    <= pos_q + 1'b1;
    end
    if (cmd_i.rd_eval) begin
      j_q         <= j_q + 1'b1;
      visited_q   <= visited_q + 1'b1;
      grp_end_q   <= (j_q == '1);
      // Restart the empty flag at each group's first slot.
      saw_empty_q <= ((j_q == '0) ? 1'b0 : saw_empty_q) | is_empty;
      if (ctrl_rd_q == {1'b0, tag_q} && key_rd_q == key_q) begin
        hit_q_v <= 1'b1;
        hit_q   <= rd_pos_q;
      end else if (is_empty || ctrl_rd_q == sth_pkg::CtrlDeleted) begin
        if (!free_v_q) begin
          free_v_q <= 1'b1;
          free_q   <= rd_pos_q;
        end
      end
    end
  end

  always_comb begin
    stat_o.clear_last = (clr_q == '1);
    stat_o.hit        = hit_q_v;
    stat_o.group_end  = grp_end_q;
    stat_o.saw_empty  = saw_empty_q;
    stat_o.all_seen   = (visited_q == (sth_pkg::SlotW + 1)'(sth_pkg::Capacity));
    stat_o.have_free  = free_v_q;
    stat_o.load_full  = (load_calc >= sth_pkg::LoadLimit);
  end

  assign hit_slot_o  = hit_q;
  assign free_slot_o = free_q;
  assign value_o     = val_rd_q;

endmodule

// ===== src/sth_ctrl.sv =====
// Controller FSM: sequences hashing, probing and the result beat.
// Depends on sth_pkg; drives sth_datapath through sth_cmd_t.
module sth_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sth_pkg::sth_cmd_t   dp_cmd_o,
  output logic [2:0]          mul_idx_o,
  input  sth_pkg::sth_stat_t  stat_i,
  input  logic [sth_pkg::SlotW-1:0] hit_slot_i,
  input  logic [sth_pkg::SlotW-1:0] free_slot_i,
  input  logic [63:0]         value_i,
  output logic [2:0]          status_o,
  output logic [sth_pkg::SlotW-1:0] slot_o,
  output logic [63:0]         value_out_o
);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SHash  = 4'd1;
  localparam logic [3:0] SMul   = 4'd2;
  localparam logic [3:0] SBase  = 4'd3;
  localparam logic [3:0] SIssue = 4'd4;
  localparam logic [3:0] SEval  = 4'd5;
  localparam logic [3:0] SCheck = 4'd6;
  localparam logic [3:0] SValue = 4'd7;
  localparam logic [3:0] SValW  = 4'd8;
  localparam logic [3:0] SOut   = 4'd9;
  localparam logic [3:0] SClear = 4'd10;

  logic [3:0] state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] cmd_q;
  logic [2:0] status_q, status_d;
  logic [sth_pkg::SlotW-1:0] slot_q, slot_d;
  logic [63:0] vout_q, vout_d;
  logic accept, out_busy;

  assign out_busy   = (state_q == SOut);
  assign in_ready_o = (state_q == SIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign out_valid_o = out_busy;
  assign mul_idx_o  = cnt_q;
  assign status_o = status_q;
  assign slot_o = slot_q;
  assign value_out_o = vout_q;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    slot_d   = slot_q;
    vout_d   = vout_q;
    dp_cmd_o = '0;
    case (state_q)
      SClear: begin
        dp_cmd_o.clear_step = 1'b1;
        if (stat_i.clear_last) state_d = SIdle;
      end
      SIdle: if (accept) begin
        dp_cmd_o.load = 1'b1;
        cnt_d = '0;
        slot_d = '0;
        vout_d = '0;
        state_d = SHash;
      end
      SHash: begin
        case (cmd_q)
          sth_pkg::CmdWrite: begin
            dp_cmd_o.do_write = 1'b1;
            status_d = sth_pkg::StWritten;
            state_d = SOut;
          end
          sth_pkg::CmdGetIns, sth_pkg::CmdDelete: begin
            dp_cmd_o.hash_step = 1'b1;
            cnt_d = cnt_q + 1'b1;
            if (cnt_q == 3'd7) state_d = SMul;
          end
          default: begin
            status_d = sth_pkg::StNotFound;
            state_d = SOut;
          end
        endcase
      end
      SMul: begin
        dp_cmd_o.mul_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 3'd2) state_d = SBase;
      end
      SBase: begin
        dp_cmd_o.set_base = 1'b1;
        state_d = SIssue;
      end
      SIssue: begin
        dp_cmd_o.rd_issue = 1'b1;
        state_d = SEval;
      end
      SEval: begin
        dp_cmd_o.rd_eval = 1'b1;
        state_d = SCheck;
      end
      SCheck: begin
        // Stop on hit, on a finished group that held an empty, or after all slots.
        if (stat_i.hit || (stat_i.group_end && stat_i.saw_empty) || stat_i.all_seen) begin
          if (cmd_q == sth_pkg::CmdDelete) begin
            if (stat_i.hit) begin
              dp_cmd_o.do_delete = 1'b1;
              status_d = sth_pkg::StDeleted;
            end else begin
              status_d = sth_pkg::StNotFound;
            end
            state_d = SOut;
          end else if (stat_i.hit) begin
            status_d = sth_pkg::StFound;
            slot_d = hit_slot_i;
            state_d = SValue;
          end else if (!stat_i.have_free || stat_i.load_full) begin
            status_d = sth_pkg::StFull;
            state_d = SOut;
          end else begin
            dp_cmd_o.do_insert = 1'b1;
            status_d = sth_pkg::StInserted;
            slot_d = free_slot_i;
            state_d = SOut;
          end
        end else begin
          state_d = SIssue;
        end
      end
      SValue: begin
        dp_cmd_o.rd_value = 1'b1;
        state_d = SValW;
      end
      SValW: begin
        vout_d = value_i;
        state_d = SOut;
      end
      SOut: if (out_ready_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) cmd_q <= cmd_i;
    status_q <= status_d;
    slot_q   <= slot_d;
    vout_q   <= vout_d;
  end

endmodule

// ===== src/swiss_table_hash_engine.sv =====
// Top level of the open-addressed hash table engine.
// Depends on sth_pkg, sth_ctrl and sth_datapath.
//
//   channel | valid/ready        | fields
//   in      | in_valid_i/ready_o | cmd_i, key_i, slot_sel_i, value_in_i
//   out     | out_valid_o/ready_i| status_o, slot_o, value_out_o
//
// One item at a time. A write or an unused command goes from accept through the
// hash state to the result; get_or_insert and delete take the accept, the hash
// rounds, the multiply steps, the base step, an issue, evaluate and check step per
// probed slot and the result, plus a value read and wait for a found key.
// After reset a clearing pass marks every slot empty; in_ready_o stays low until
// it ends. Reset also clears the FSM and the live count.
// The result holds in its register while out_ready_i is low; input waits.
module swiss_table_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [63:0] key_i,
  input  logic [9:0]  slot_sel_i,
  input  logic [63:0] value_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [9:0]  slot_o,
  output logic [63:0] value_out_o
);

  sth_pkg::sth_cmd_t  dp_cmd;
  sth_pkg::sth_stat_t dp_stat;
  logic [2:0]  mul_idx;
  logic [9:0]  hit_slot, free_slot;
  logic [63:0] dp_value;

  sth_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i,
    .out_valid_o, .out_ready_i,
    .dp_cmd_o(dp_cmd), .mul_idx_o(mul_idx), .stat_i(dp_stat),
    .hit_slot_i(hit_slot), .free_slot_i(free_slot), .value_i(dp_value),
    .status_o, .slot_o, .value_out_o
  );

  sth_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(dp_cmd), .key_i, .slot_sel_i,
    .value_in_i, .mul_idx_i(mul_idx), .stat_o(dp_stat),
    .hit_slot_o(hit_slot), .free_slot_o(free_slot), .value_o(dp_value)
  );

`ifndef SYNTH
  // Never accept a new item while a result is still offered.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("accept during result");
  // Insert and delete never fire in the same cycle.
  a_one_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dp_cmd.do_insert && dp_cmd.do_delete)) else $error("double update");
  // A result beat follows an insert.
  a_ins_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.do_insert |=> out_valid_o) else $error("insert without result");
`endif

endmodule
